### hw/rtl/soxp_pkg.sv
package soxp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       request_start;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] dst_port;
    logic [31:0] dest_ip;
    logic [7:0]  name_byte;
    logic        name_byte_valid;
  } res_t;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_USERID   = 5'b00010,
    PH_NAME     = 5'b00100,
    PH_DONE     = 5'b01000,
    PH_REJECTED = 5'b10000
  } phase_t;

  localparam logic [2:0] ST_BUSY        = 3'd0;
  localparam logic [2:0] ST_DONE_IP     = 3'd1;
  localparam logic [2:0] ST_DONE_NAME   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_COMMAND = 3'd4;
  localparam logic [2:0] ST_ZERO_PORT   = 3'd5;
  localparam logic [2:0] ST_NAME_LONG   = 3'd6;
  localparam logic [2:0] ST_IGNORED     = 3'd7;

  localparam logic [7:0] PROTO_VERSION    = 8'd4;
  localparam logic [7:0] SOCKS_CONNECT    = 8'd1;
  localparam logic [9:0] NAME_LIMIT_RESET = 10'd500;

  localparam logic [2:0] HDR_VERSION  = 3'd0;
  localparam logic [2:0] HDR_COMMAND  = 3'd1;
  localparam logic [2:0] HDR_PORT_HI  = 3'd2;
  localparam logic [2:0] HDR_PORT_LO  = 3'd3;
  localparam logic [2:0] HDR_LAST     = 3'd7;

endpackage

### hw/rtl/socks4a_request_parser_unit.sv
// result: registered, on res in the cycle after an item is accepted
// throughput: one item per cycle while res_ready is high; the result register frees each cycle it is taken
// the parser state updates in the same cycle as the accept, so items chain with no gap
// reset (rst, synchronous): parser in header phase, no result pending,
// max_name_len back to 500
module socks4a_request_parser_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  soxp_pkg::req_t    req,
  output logic              res_valid,
  input  logic              res_ready,
  output soxp_pkg::res_t    res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [9:0]        cfg_data
);

  soxp_pkg::phase_t phase, phase_next, phase_cur;
  logic [2:0]  header_index, header_index_next, header_index_cur;
  logic [7:0]  version_seen, version_seen_next;
  logic [7:0]  command_seen, command_seen_next;
  logic [15:0] port_value, port_value_next;
  logic [31:0] ip_value, ip_value_next;
  logic [9:0]  name_count, name_count_next, name_count_cur;
  logic [9:0]  max_name_len;
  soxp_pkg::res_t res_next;
  logic accept;

  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_cur         = req.request_start ? soxp_pkg::PH_HEADER : phase;
    header_index_cur  = req.request_start ? 3'd0 : header_index;
    name_count_cur    = req.request_start ? 10'd0 : name_count;
    phase_next        = phase_cur;
    header_index_next = header_index_cur;
    name_count_next   = name_count_cur;
    version_seen_next = version_seen;
    command_seen_next = command_seen;
    port_value_next   = port_value;
    ip_value_next     = ip_value;
    res_next          = '0;
    res_next.status   = soxp_pkg::ST_BUSY;
    case (phase_cur)
      soxp_pkg::PH_HEADER: begin
        case (header_index_cur)
          soxp_pkg::HDR_VERSION: version_seen_next = req.data_byte;
          soxp_pkg::HDR_COMMAND: command_seen_next = req.data_byte;
          soxp_pkg::HDR_PORT_HI: port_value_next = {req.data_byte, port_value[7:0]};
          soxp_pkg::HDR_PORT_LO: port_value_next = {port_value[15:8], req.data_byte};
          default:               ip_value_next = {ip_value[23:0], req.data_byte};
        endcase
        header_index_next = header_index_cur + 3'd1;
        if (header_index_cur == soxp_pkg::HDR_LAST) begin
          if (version_seen_next != soxp_pkg::PROTO_VERSION) begin
            res_next.status = soxp_pkg::ST_BAD_VERSION;
            phase_next      = soxp_pkg::PH_REJECTED;
          end else if (command_seen_next != soxp_pkg::SOCKS_CONNECT) begin
            res_next.status = soxp_pkg::ST_BAD_COMMAND;
            phase_next      = soxp_pkg::PH_REJECTED;
          end else if (port_value_next == 16'd0) begin
            res_next.status = soxp_pkg::ST_ZERO_PORT;
            phase_next      = soxp_pkg::PH_REJECTED;
          end else begin
            phase_next = soxp_pkg::PH_USERID;
          end
        end
      end
      soxp_pkg::PH_USERID: begin
        if (req.data_byte == 8'd0) begin
          if (ip_value[31:8] == 24'd0 && ip_value[7:0] != 8'd0) begin
            phase_next = soxp_pkg::PH_NAME;
          end else begin
            phase_next      = soxp_pkg::PH_DONE;
            res_next.status = soxp_pkg::ST_DONE_IP;
          end
        end
      end
      soxp_pkg::PH_NAME: begin
        if (name_count_cur >= max_name_len) begin
          res_next.status = soxp_pkg::ST_NAME_LONG;
          phase_next      = soxp_pkg::PH_REJECTED;
        end else begin
          name_count_next = name_count_cur + 10'd1;
          if (req.data_byte == 8'd0) begin
            res_next.status = soxp_pkg::ST_DONE_NAME;
            phase_next      = soxp_pkg::PH_DONE;
          end else begin
            res_next.name_byte       = req.data_byte;
            res_next.name_byte_valid = 1'b1;
          end
        end
      end
      default: begin
        res_next.status = soxp_pkg::ST_IGNORED;
      end
    endcase
    if (phase_next == soxp_pkg::PH_USERID || phase_next == soxp_pkg::PH_NAME ||
        phase_next == soxp_pkg::PH_DONE) begin
      res_next.dst_port = port_value_next;
      res_next.dest_ip  = ip_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= soxp_pkg::PH_HEADER;
      header_index <= 3'd0;
      name_count   <= 10'd0;
      max_name_len <= soxp_pkg::NAME_LIMIT_RESET;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_name_len <= cfg_data;
      end
      if (accept) begin
        phase        <= phase_next;
        header_index <= header_index_next;
        name_count   <= name_count_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      version_seen <= version_seen_next;
      command_seen <= command_seen_next;
      port_value   <= port_value_next;
      ip_value     <= ip_value_next;
      res          <= res_next;
    end
  end

endmodule

### test/tb_socks4a_request_parser_unit.sv
class request_tracker;
  soxp_pkg::res_t   reply_q[$];
  soxp_pkg::phase_t ph;
  logic [2:0]  hdr_idx;
  logic [7:0]  ver;
  logic [7:0]  cmd;
  logic [15:0] port;
  logic [31:0] ip;
  logic [9:0]  name_cnt;
  logic [9:0]  name_limit;
  int          mismatches;
  int          checked;
  int          name_bytes;
  int          hits[8];

  function new();
    name_limit = soxp_pkg::NAME_LIMIT_RESET;
    restart();
  endfunction

  function void restart();
    ph = soxp_pkg::PH_HEADER;
    hdr_idx = '0;
    ver = '0;
    cmd = '0;
    port = '0;
    ip = '0;
    name_cnt = '0;
  endfunction

  // expected reply for one accepted byte
  function void accept_byte(soxp_pkg::req_t r);
    soxp_pkg::res_t e;
    logic [7:0]     b;
    b = r.data_byte;
    e = '0;
    e.status = soxp_pkg::ST_BUSY;
    if (r.request_start) restart();
    case (ph)
      soxp_pkg::PH_HEADER: begin
        case (hdr_idx)
          soxp_pkg::HDR_VERSION: ver = b;
          soxp_pkg::HDR_COMMAND: cmd = b;
          soxp_pkg::HDR_PORT_HI: port[15:8] = b;
          soxp_pkg::HDR_PORT_LO: port[7:0] = b;
          default: ip = {ip[23:0], b};
        endcase
        if (hdr_idx == soxp_pkg::HDR_LAST) begin
          hdr_idx = '0;
          if (ver != soxp_pkg::PROTO_VERSION) begin
            e.status = soxp_pkg::ST_BAD_VERSION;
            ph = soxp_pkg::PH_REJECTED;
          end else if (cmd != soxp_pkg::SOCKS_CONNECT) begin
            e.status = soxp_pkg::ST_BAD_COMMAND;
            ph = soxp_pkg::PH_REJECTED;
          end else if (port == 16'd0) begin
            e.status = soxp_pkg::ST_ZERO_PORT;
            ph = soxp_pkg::PH_REJECTED;
          end else begin
            ph = soxp_pkg::PH_USERID;
          end
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      soxp_pkg::PH_USERID: begin
        if (b == 8'd0) begin
          // 0.0.0.x with x nonzero: hostname follows
          if (ip[31:8] == 24'd0 && ip[7:0] != 8'd0) begin
            ph = soxp_pkg::PH_NAME;
          end else begin
            ph = soxp_pkg::PH_DONE;
            e.status = soxp_pkg::ST_DONE_IP;
          end
        end
      end
      soxp_pkg::PH_NAME: begin
        if (name_cnt >= name_limit) begin
          e.status = soxp_pkg::ST_NAME_LONG;
          ph = soxp_pkg::PH_REJECTED;
        end else begin
          name_cnt = name_cnt + 10'd1;
          if (b == 8'd0) begin
            e.status = soxp_pkg::ST_DONE_NAME;
            ph = soxp_pkg::PH_DONE;
          end else begin
            e.name_byte = b;
            e.name_byte_valid = 1'b1;
          end
        end
      end
      default: e.status = soxp_pkg::ST_IGNORED;
    endcase
    if (ph == soxp_pkg::PH_USERID || ph == soxp_pkg::PH_NAME || ph == soxp_pkg::PH_DONE) begin
      e.dst_port = port;
      e.dest_ip = ip;
    end
    reply_q.push_back(e);
  endfunction

  function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  function void check_reply(soxp_pkg::res_t got);
    soxp_pkg::res_t e;
    if (reply_q.size() == 0) begin
      $display("%0t: result with no item pending, actual status %0d", $time, got.status);
      mismatches++;
      return;
    end
    e = reply_q.pop_front();
    checked++;
    hits[e.status]++;
    if (e.name_byte_valid) name_bytes++;
    cmp_field("status", 32'(e.status), 32'(got.status));
    cmp_field("dst_port", 32'(e.dst_port), 32'(got.dst_port));
    cmp_field("dest_ip", e.dest_ip, got.dest_ip);
    cmp_field("name_byte", 32'(e.name_byte), 32'(got.name_byte));
    cmp_field("name_byte_valid", 32'(e.name_byte_valid), 32'(got.name_byte_valid));
  endfunction
endclass

module tb_socks4a_request_parser_unit;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  soxp_pkg::req_t req_bus;
  logic           res_valid;
  logic           res_ready;
  soxp_pkg::res_t res_bus;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [9:0]     cfg_data;

  request_tracker tracker;
  logic [7:0]     pkt[$];
  int             send_idle;
  int             recv_stall;
  int             hold_left;
  int             cycles;
  int             bytes_sent;
  int             requests_sent;

  always #2 clk = ~clk;

  socks4a_request_parser_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_bus),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res_bus),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) tracker.check_reply(res_bus);
  end

  task automatic push_byte(input logic [7:0] b, input logic s);
    soxp_pkg::req_t r;
    r.data_byte = b;
    r.request_start = s;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_bus <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    tracker.accept_byte(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == 0);
    requests_sent++;
  endtask

  task automatic add_header(input logic [7:0] v, input logic [7:0] c,
                            input logic [15:0] p, input logic [31:0] a);
    pkt.push_back(v);
    pkt.push_back(c);
    pkt.push_back(p[15:8]);
    pkt.push_back(p[7:0]);
    pkt.push_back(a[31:24]);
    pkt.push_back(a[23:16]);
    pkt.push_back(a[15:8]);
    pkt.push_back(a[7:0]);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (tracker.reply_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [9:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.name_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_request();
    int          lim;
    int          nlen;
    int          sel;
    int          keep;
    logic [7:0]  ver;
    logic [7:0]  cmd;
    logic [15:0] port;
    logic [31:0] ip;
    pkt.delete();
    // line noise with random restarts
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom), $urandom_range(3) == 0);
      return;
    end
    ver = ($urandom_range(11) == 0) ? 8'($urandom) : soxp_pkg::PROTO_VERSION;
    cmd = ($urandom_range(11) == 0) ? 8'($urandom) : soxp_pkg::SOCKS_CONNECT;
    port = ($urandom_range(11) == 0) ? 16'd0 : 16'($urandom);
    sel = $urandom_range(9);
    if (sel < 5) ip = {24'd0, 8'($urandom_range(1, 255))};
    else if (sel == 5) ip = 32'd0;
    else ip = $urandom;
    add_header(ver, cmd, port, ip);
    repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'd0);
    if (ip[31:8] == 24'd0 && ip[7:0] != 8'd0) begin
      lim = tracker.name_limit;
      // names around the limit when it is short enough to reach
      if (lim <= 40 && $urandom_range(2) == 0)
        nlen = (lim == 0 ? 0 : lim - 1) + $urandom_range(0, 2);
      else nlen = $urandom_range(0, 6);
      repeat (nlen) pkt.push_back(8'($urandom_range(1, 255)));
      pkt.push_back(8'd0);
    end
    repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
    if ($urandom_range(7) == 0) begin
      keep = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    send_packet();
  endtask

  task automatic run_phase(input int n, input int s_idle, input int r_stall, input bit pause);
    int stop;
    stop = bytes_sent + n;
    send_idle = s_idle;
    recv_stall = r_stall;
    while (bytes_sent < stop) begin
      send_request();
      if (pause && $urandom_range(3) == 0) drain();
    end
    drain();
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req_bus = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_left = 0;
    cycles = 0;
    bytes_sent = 0;
    requests_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_limit(10'd1);
    // address 0.0.0.0 completes on the user id, then a stray byte
    pkt.delete();
    add_header(soxp_pkg::PROTO_VERSION, soxp_pkg::SOCKS_CONNECT, 16'hFFFF, 32'd0);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    send_packet();
    // restart in the middle of a header
    pkt.delete();
    pkt.push_back(soxp_pkg::PROTO_VERSION);
    pkt.push_back(soxp_pkg::SOCKS_CONNECT);
    send_packet();
    // hostname past a limit of one, then a byte after rejection
    pkt.delete();
    add_header(soxp_pkg::PROTO_VERSION, soxp_pkg::SOCKS_CONNECT, 16'h0001, 32'h0000_00FF);
    pkt.push_back(8'h00);
    pkt.push_back(8'h41);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    send_packet();
    drain();

    write_limit(10'd1000);
    run_phase(65, 0, 0, 1'b0);
    write_limit(10'd5);
    run_phase(65, 54, 0, 1'b0);
    write_limit(10'd0);
    run_phase(65, 0, 54, 1'b0);
    write_limit(10'($urandom_range(1, 12)));
    run_phase(65, 23, 23, 1'b1);
    write_limit(soxp_pkg::NAME_LIMIT_RESET);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    run_phase(65, 0, 0, 1'b0);
    write_limit(10'($urandom_range(1, 1000)));
    run_phase(65, 23, 54, 1'b0);

    repeat (10) @(negedge clk);
    if (tracker.reply_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.reply_q.size());
      tracker.mismatches++;
    end
    $display("%0d bytes in %0d requests, %0d replies checked, %0d hostname bytes",
             bytes_sent, requests_sent, tracker.checked, tracker.name_bytes);
    $display("ip %0d, name %0d, bad version %0d, bad command %0d, zero port %0d, too long %0d",
             tracker.hits[soxp_pkg::ST_DONE_IP], tracker.hits[soxp_pkg::ST_DONE_NAME],
             tracker.hits[soxp_pkg::ST_BAD_VERSION], tracker.hits[soxp_pkg::ST_BAD_COMMAND],
             tracker.hits[soxp_pkg::ST_ZERO_PORT], tracker.hits[soxp_pkg::ST_NAME_LONG]);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
